@@ hdl/spq_pkg.sv @@
// shared types and codes for the sorted priority queue
package spq_pkg;

    localparam int VALUE_W  = 32;
    localparam int PRIO_W   = 16;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    // request kinds
    localparam logic REQ_ENQ = 1'b0;
    localparam logic REQ_DEQ = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic        [PRIO_W-1:0]  prio;
    } entry_t;

    // operation broadcast to every cell of the row
    typedef struct packed {
        logic   enq;
        logic   deq;
        entry_t ent;
    } op_t;

endpackage

@@ hdl/spq_if.sv @@
// request and result channel interfaces
interface spq_req_if;
    logic                       valid;
    logic                       ready;
    logic                       req_type;
    logic signed [31:0]         value;
    logic        [15:0]         priority_req;

    modport source (output valid, output req_type, output value, output priority_req,
                    input ready);
    modport sink   (input valid, input req_type, input value, input priority_req,
                    output ready);
endinterface

interface spq_rsp_if;
    logic                       valid;
    logic                       ready;
    logic        [1:0]          status;
    logic signed [31:0]         out_value;
    logic        [4:0]          count;
    logic                       is_empty;

    modport source (output valid, output status, output out_value, output count,
                    output is_empty, input ready);
    modport sink   (input valid, input status, input out_value, input count,
                    input is_empty, output ready);
endinterface

@@ hdl/spq_cell.sv @@
// one storage cell of the sorted row
module spq_cell
    import spq_pkg::*;
(
    input  logic   clk,
    input  op_t    op,
    input  logic   valid,
    input  entry_t left_ent,
    input  logic   left_keep,
    input  entry_t right_ent,
    output entry_t ent,
    output logic   keep
);

    entry_t entry_reg;
    entry_t entry_next;

    // held entry stays in place when it outranks or ties the newcomer
    assign keep = valid && (entry_reg.prio >= op.ent.prio);
    assign ent  = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        priority if (op.enq)
        begin
            if (!keep)
            begin
                entry_next = left_keep ? op.ent : left_ent;
            end
        end
        else if (op.deq)
        begin
            entry_next = right_ent;
        end
        else
        begin
            // idle cycle, entry held
            entry_next = entry_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

@@ hdl/spq_row.sv @@
// row of cells holding the entries in priority order
module spq_row
    import spq_pkg::*;
#(
    parameter int CAPACITY = 16
)
(
    input  logic                               clk,
    input  op_t                                op,
    input  logic [$clog2(CAPACITY+1)-1:0]      count,
    output entry_t                             head
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    entry_t ents  [CAPACITY];
    logic   keeps [CAPACITY];

    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++)
        begin : g_cell
            localparam logic [CNT_W-1:0] IDX = CNT_W'(i);
            entry_t left_ent;
            logic   left_keep;
            entry_t right_ent;

            if (i == 0)
            begin : g_first
                // head cell takes the newcomer whenever it does not keep
                assign left_ent  = op.ent;
                assign left_keep = 1'b0;
            end
            else
            begin : g_inner
                assign left_ent  = ents[i-1];
                assign left_keep = keeps[i-1];
            end

            if (i == CAPACITY - 1)
            begin : g_last
                assign right_ent = ents[i];
            end
            else
            begin : g_mid
                assign right_ent = ents[i+1];
            end

            spq_cell u_cell (
                .clk       (clk),
                .op        (op),
                .valid     (IDX < count),
                .left_ent  (left_ent),
                .left_keep (left_keep),
                .right_ent (right_ent),
                .ent       (ents[i]),
                .keep      (keeps[i])
            );
        end
    endgenerate

    assign head = ents[0];

endmodule

@@ hdl/sorted_priority_queue_top.sv @@
// top level of the sorted priority queue
//
//  channel | dir | handshake     | payload
//  --------+-----+---------------+-------------------------------------------
//  req     | in  | valid / ready | req_type, value, priority_req
//  rsp     | out | valid / ready | status, out_value, count, is_empty
//
// one request per cycle unless rsp stalls: every cell decides keep, shift or
// insert locally in the same cycle, so a request is fully applied at the edge
// that accepts it, where the result is also captured in the output register
// rsp stalls hold the result; req stays ready while the register drains
// reset clears the entry count and the output valid; cell contents are not reset
module sorted_priority_queue_top
    import spq_pkg::*;
#(
    parameter int CAPACITY = 16
)
(
    input  logic          clk,
    input  logic          rst_n,
    spq_req_if.sink       req,
    spq_rsp_if.source     rsp
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [CNT_W-1:0]          count_reg;
    logic [CNT_W-1:0]          count_next;
    logic                      rsp_valid_reg;
    logic [STATUS_W-1:0]       status_reg;
    logic [STATUS_W-1:0]       status_next;
    logic signed [VALUE_W-1:0] value_reg;
    logic signed [VALUE_W-1:0] value_next;
    logic [COUNT_W-1:0]        rsp_count_reg;
    logic                      empty_reg;

    logic                      accept;
    logic                      is_deq;
    logic                      full;
    logic                      empty;
    op_t                       op;
    entry_t                    head;
    logic [CNT_W+COUNT_W-1:0]  count_wide;

    // output register frees up when empty or being drained
    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;

    assign is_deq = (req.req_type == REQ_DEQ);
    assign full   = (count_reg == CNT_W'(CAPACITY));
    assign empty  = (count_reg == '0);

    // operation broadcast along the row
    assign op.enq       = accept && !is_deq && !full;
    assign op.deq       = accept && is_deq && !empty;
    assign op.ent.value = req.value;
    assign op.ent.prio  = req.priority_req;

    spq_row #(
        .CAPACITY (CAPACITY)
    ) u_row (
        .clk   (clk),
        .op    (op),
        .count (count_reg),
        .head  (head)
    );

    always_comb
    begin
        count_next  = count_reg;
        status_next = STAT_OK;
        value_next  = '0;
        priority if (op.enq)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (op.deq)
        begin
            count_next = count_reg - CNT_W'(1);
            value_next = head.value;
        end
        else if (is_deq)
        begin
            // dequeue on an empty queue
            status_next = STAT_EMPTY;
        end
        else
        begin
            // enqueue dropped, queue full
            status_next = STAT_FULL;
        end
    end

    // result count is the low bits of the entry count
    assign count_wide = (CNT_W + COUNT_W)'(count_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (accept)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg    <= status_next;
            value_reg     <= value_next;
            rsp_count_reg <= count_wide[COUNT_W-1:0];
            empty_reg     <= (count_next == '0);
        end
    end

    assign rsp.valid     = rsp_valid_reg;
    assign rsp.status    = status_reg;
    assign rsp.out_value = value_reg;
    assign rsp.count     = rsp_count_reg;
    assign rsp.is_empty  = empty_reg;

endmodule

@@ tb/testbench.sv @@
// self-checking testbench for the sorted priority queue top level
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import spq_pkg::*;

    localparam int CAPACITY     = 16;
    localparam int CALM_TAIL    = 100;   // requests at the end with no idling
    localparam int QUIET_LIMIT  = 2000;  // cycles with no handshake before giving up
    localparam int DRAIN_CYCLES = 8;     // settle time once nothing is expected
    localparam int RANDOM_COUNT = 650;

    // one request as offered on the input channel
    typedef struct {
        logic               kind;
        logic signed [31:0] value;
        logic        [15:0] prio;
    } queue_request_t;

    // one result as expected on the output channel
    typedef struct {
        logic        [STATUS_W-1:0] status;
        logic signed [VALUE_W-1:0]  out_value;
        logic        [COUNT_W-1:0]  count;
        logic                       is_empty;
    } queue_result_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    spq_req_if req_ch ();
    spq_rsp_if rsp_ch ();

    sorted_priority_queue_top #(
        .CAPACITY (CAPACITY)
    ) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // shadow of the queue contents, head at index 0, kept in sorted order
    // ------------------------------------------------------------------
    entry_t shadow_entries [CAPACITY];
    int     shadow_count = 0;

    queue_request_t pending_requests [$];
    queue_result_t  expected_results [$];

    int total_requests = 0;
    int accepted_count = 0;
    int quiet_cycles   = 0;
    int error_count    = 0;
    int cycle_no       = 0;
    int idle_level     = 1;   // 0 none, 1 light, 2 heavy

    // apply one request to the shadow queue and return the result it gives
    function automatic queue_result_t apply_request(queue_request_t rq);
        queue_result_t res;
        int            pos;
        res.status    = STAT_OK;
        res.out_value = '0;
        if (rq.kind == REQ_DEQ) begin
            if (shadow_count == 0) begin
                // nothing held: state untouched, empty status
                res.status = STAT_EMPTY;
            end
            else begin
                res.out_value = shadow_entries[0].value;
                for (int i = 1; i < shadow_count; i++)
                    shadow_entries[i-1] = shadow_entries[i];
                shadow_count--;
            end
        end
        else if (shadow_count >= CAPACITY) begin
            // full: the request is dropped
            res.status = STAT_FULL;
        end
        else begin
            // new entry goes behind every entry of greater or equal priority
            pos = 0;
            while (pos < shadow_count && shadow_entries[pos].prio >= rq.prio)
                pos++;
            for (int i = shadow_count; i > pos; i--)
                shadow_entries[i] = shadow_entries[i-1];
            shadow_entries[pos].value = rq.value;
            shadow_entries[pos].prio  = rq.prio;
            shadow_count++;
        end
        res.count    = COUNT_W'(shadow_count);
        res.is_empty = (shadow_count == 0);
        return res;
    endfunction

    task automatic check_field(string name, longint expv, longint actv);
        if (expv !== actv) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, expv, actv);
            error_count++;
        end
    endtask

    task automatic add_request(logic kind, logic signed [31:0] value, logic [15:0] prio);
        queue_request_t rq;
        rq.kind  = kind;
        rq.value = value;
        rq.prio  = prio;
        pending_requests.push_back(rq);
    endtask

    // priorities drawn so that ties, extremes and wide spreads all occur
    function automatic logic [15:0] pick_priority();
        case ($urandom_range(0, 3))
            0:       return 16'($urandom_range(0, 3));
            1:       return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7FFF_FFFF;
            2:       return 32'sh0000_0000;
            3:       return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    // no idling near the end of the run
    wire calm = (accepted_count >= total_requests - CALM_TAIL);

    // idling intensity is redrawn at intervals set by the cycle counter, so that quiet stretches occur
    always @(posedge clk) begin
        cycle_no <= cycle_no + 1;
        if (cycle_no % 64 == 0)
            idle_level <= $urandom_range(0, 2);
    end

    function automatic bit start_burst();
        if (calm || idle_level == 0)
            return 1'b0;
        return (idle_level == 1) ? ($urandom_range(0, 7) == 0) : ($urandom_range(0, 2) == 0);
    endfunction

    // ------------------------------------------------------------------
    // request driver: pops the pending queue, inserts idle bursts between requests
    // ------------------------------------------------------------------
    int             gap_left;
    queue_request_t next_rq;

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            req_ch.valid        <= 1'b0;
            req_ch.req_type     <= REQ_ENQ;
            req_ch.value        <= '0;
            req_ch.priority_req <= '0;
            gap_left            <= 0;
        end
        else if (req_ch.valid && !req_ch.ready) begin
            // hold the offered request until it is taken
        end
        else if (gap_left > 0) begin
            req_ch.valid <= 1'b0;
            gap_left     <= gap_left - 1;
        end
        else if (pending_requests.size() == 0) begin
            req_ch.valid <= 1'b0;
        end
        else if (start_burst()) begin
            req_ch.valid <= 1'b0;
            gap_left     <= $urandom_range(0, 3);
        end
        else begin
            next_rq = pending_requests.pop_front();
            req_ch.valid        <= 1'b1;
            req_ch.req_type     <= next_rq.kind;
            req_ch.value        <= next_rq.value;
            req_ch.priority_req <= next_rq.prio;
        end
    end

    // ------------------------------------------------------------------
    // result sink: ready drops in randomly started bursts
    // ------------------------------------------------------------------
    int stall_left;

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            rsp_ch.ready <= 1'b0;
            stall_left   <= 0;
        end
        else if (stall_left > 0) begin
            rsp_ch.ready <= 1'b0;
            stall_left   <= stall_left - 1;
        end
        else if (start_burst()) begin
            rsp_ch.ready <= 1'b0;
            stall_left   <= $urandom_range(0, 3);
        end
        else begin
            rsp_ch.ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // monitor: check results first, then predict from the accepted request
    // ------------------------------------------------------------------
    queue_result_t  want;
    queue_request_t taken;

    always @(posedge clk) begin
        if (rst_n) begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got status %0d value %0d",
                             $time, rsp_ch.status, rsp_ch.out_value);
                    error_count++;
                end
                else begin
                    want = expected_results.pop_front();
                    check_field("status", want.status, rsp_ch.status);
                    check_field("out_value", want.out_value, rsp_ch.out_value);
                    check_field("count", want.count, rsp_ch.count);
                    check_field("is_empty", want.is_empty, rsp_ch.is_empty);
                end
            end
            if (req_ch.valid && req_ch.ready) begin
                taken.kind  = req_ch.req_type;
                taken.value = req_ch.value;
                taken.prio  = req_ch.priority_req;
                expected_results.push_back(apply_request(taken));
                accepted_count <= accepted_count + 1;
            end
            // watchdog counter: cycles with no handshake on either side
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // watchdog
    initial begin
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge clk);
        $display("sorted_priority_queue_top regression: fail");
        $finish;
    end

    // ------------------------------------------------------------------
    // stimulus and end of run
    // ------------------------------------------------------------------
    int phase_len;
    int deq_pct;
    int made;

    initial begin
        // directed: dequeue on empty, fill to capacity with extreme values,
        // ties on top and bottom priority, then an enqueue when full
        add_request(REQ_DEQ, 32'sh7FFF_FFFF, 16'hFFFF);
        add_request(REQ_ENQ, 32'sh8000_0000, 16'h0000);
        add_request(REQ_ENQ, 32'sh7FFF_FFFF, 16'hFFFF);
        add_request(REQ_ENQ, 32'sh0000_0000, 16'hFFFF);
        add_request(REQ_ENQ, -32'sd1,        16'h0000);
        add_request(REQ_ENQ, 32'sh5555_5555, 16'h8000);
        add_request(REQ_ENQ, 32'shAAAA_AAAA, 16'h7FFF);
        add_request(REQ_ENQ, 32'sd1,         16'h5555);
        add_request(REQ_ENQ, 32'sd2,         16'hAAAA);
        for (int i = 0; i < 8; i++)
            add_request(REQ_ENQ, 32'sh1000_0000 + i, (i % 2) ? 16'h0001 : 16'h8000);
        // full queue drops even a top-priority request
        add_request(REQ_ENQ, 32'sh1234_5678, 16'hFFFF);
        for (int i = 0; i < 5; i++)
            add_request(REQ_DEQ, 32'sh0000_0000, 16'h0000);

        // random: phases biased towards filling, draining or a mix, so the
        // queue keeps swinging between empty and full
        made = 0;
        while (made < RANDOM_COUNT) begin
            phase_len = $urandom_range(8, 40);
            case ($urandom_range(0, 2))
                0:       deq_pct = 15;
                1:       deq_pct = 85;
                default: deq_pct = 50;
            endcase
            for (int i = 0; i < phase_len; i++) begin
                add_request(($urandom_range(0, 99) < deq_pct) ? REQ_DEQ : REQ_ENQ,
                            pick_value(), pick_priority());
                made++;
            end
        end
        total_requests = pending_requests.size();

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        while (accepted_count < total_requests || expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0 && expected_results.size() == 0)
            $display("sorted_priority_queue_top regression: pass");
        else
            $display("sorted_priority_queue_top regression: fail");
        $finish;
    end

endmodule

@@ files.f @@
hdl/spq_pkg.sv
hdl/spq_if.sv
hdl/spq_cell.sv
hdl/spq_row.sv
hdl/sorted_priority_queue_top.sv
tb/testbench.sv
